// ===== hw/rtl/cat_pkg.sv =====
// Shared types and constants for the connection address table.
// Holds the command, status and sequencer state codes and the stream field widths.
// No dependencies.
`default_nettype none

package cat_pkg;

    localparam int CMD_W       = 2;
    localparam int HANDLE_W    = 16;
    localparam int MAC_W       = 48;
    localparam int STATUS_W    = 3;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 56;

    typedef enum logic [CMD_W-1:0] {
        CMD_REMEMBER = 2'd0,
        CMD_QUERY    = 2'd1,
        CMD_TAKE     = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_UPDATED   = 3'd0,
        STAT_INSERTED  = 3'd1,
        STAT_DROPPED   = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_RESULT = 2'd2
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/cat_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the handle and peer address stores of the table; no dependencies.
`default_nettype none

module cat_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16,
    parameter int AW    = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cat_ctrl.sv =====
// Lookup sequencer: holds the valid bits, scans the handle store one entry per cycle
// and issues the writes and the address read that finish each request. Uses cat_pkg.
`default_nettype none

module cat_ctrl #(
    parameter int TABLE_ENTRIES = 8,
    parameter int IDX_W         = 3
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_req_valid,
    output logic                                o_req_ready,
    input  wire logic [cat_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [cat_pkg::HANDLE_W-1:0]   i_handle,
    input  wire logic [cat_pkg::MAC_W-1:0]      i_mac,
    output logic                                o_res_valid,
    input  wire logic                           i_res_ready,
    output logic [cat_pkg::STATUS_W-1:0]        o_status,
    output logic [cat_pkg::MAC_W-1:0]           o_mac,
    output logic                                o_key_we,
    output logic                                o_addr_we,
    output logic [IDX_W-1:0]                    o_waddr,
    output logic [cat_pkg::HANDLE_W-1:0]        o_key_wdata,
    output logic [cat_pkg::MAC_W-1:0]           o_addr_wdata,
    output logic                                o_key_re,
    output logic [IDX_W-1:0]                    o_key_raddr,
    input  wire logic [cat_pkg::HANDLE_W-1:0]   i_key_rdata,
    output logic                                o_addr_re,
    output logic [IDX_W-1:0]                    o_addr_raddr,
    input  wire logic [cat_pkg::MAC_W-1:0]      i_addr_rdata
);

    import cat_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_state                  r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [HANDLE_W-1:0]     r_key, n_key;
    logic [MAC_W-1:0]        r_mac, n_mac;
    t_status                 r_status, n_status;
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]        r_rd_cnt, n_rd_cnt;
    logic                    r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]        r_cmp_idx, n_cmp_idx;
    logic                    r_free_found, n_free_found;
    logic [IDX_W-1:0]        r_free_idx, n_free_idx;

    logic                    hit;
    logic                    last;
    logic                    cur_free_found;
    logic [IDX_W-1:0]        cur_free_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_mac        <= n_mac;
        r_status     <= n_status;
        r_rd_cnt     <= n_rd_cnt;
        r_cmp_idx    <= n_cmp_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
    end

    always_comb begin
        hit            = r_cmp_vld && r_valid[r_cmp_idx] && (i_key_rdata == r_key);
        last           = r_cmp_vld && (r_cmp_idx == LAST_IDX);
        cur_free_found = r_free_found || (r_cmp_vld && !r_valid[r_cmp_idx]);
        cur_free_idx   = r_free_found ? r_free_idx : r_cmp_idx;
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_mac        = r_mac;
        n_status     = r_status;
        n_valid      = r_valid;
        n_rd_cnt     = r_rd_cnt;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;

        o_req_ready  = 1'b0;
        o_res_valid  = 1'b0;
        o_status     = r_status;
        o_mac        = (r_status == STAT_FOUND) ? i_addr_rdata : '0;
        o_key_we     = 1'b0;
        o_addr_we    = 1'b0;
        o_waddr      = r_cmp_idx;
        o_key_wdata  = r_key;
        o_addr_wdata = r_mac;
        o_key_re     = 1'b0;
        o_key_raddr  = r_rd_cnt[IDX_W-1:0];
        o_addr_re    = 1'b0;
        o_addr_raddr = r_cmp_idx;

        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_cmd        = t_cmd'(i_cmd);
                    n_key        = i_handle;
                    n_mac        = i_mac;
                    n_rd_cnt     = '0;
                    n_free_found = 1'b0;
                    case (t_cmd'(i_cmd))
                        CMD_REMEMBER, CMD_QUERY, CMD_TAKE: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_status = STAT_NOT_FOUND;
                            n_state  = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_rd_cnt < LAST_CNT) begin
                    o_key_re  = 1'b1;
                    n_rd_cnt  = r_rd_cnt + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_cnt[IDX_W-1:0];
                end
                if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_cmp_idx;
                end
                if (hit) begin
                    n_cmp_vld = 1'b0;
                    n_state   = ST_RESULT;
                    case (r_cmd)
                        CMD_REMEMBER: begin
                            o_addr_we = 1'b1;
                            n_status  = STAT_UPDATED;
                        end
                        CMD_TAKE: begin
                            o_addr_re            = 1'b1;
                            n_valid[r_cmp_idx]   = 1'b0;
                            n_status             = STAT_FOUND;
                        end
                        default: begin
                            o_addr_re = 1'b1;
                            n_status  = STAT_FOUND;
                        end
                    endcase
                end else if (last) begin
                    n_cmp_vld = 1'b0;
                    n_state   = ST_RESULT;
                    case (r_cmd)
                        CMD_REMEMBER: begin
                            if (cur_free_found) begin
                                o_key_we              = 1'b1;
                                o_addr_we             = 1'b1;
                                o_waddr               = cur_free_idx;
                                n_valid[cur_free_idx] = 1'b1;
                                n_status              = STAT_INSERTED;
                            end else begin
                                n_status = STAT_DROPPED;
                            end
                        end
                        default: begin
                            n_status = STAT_NOT_FOUND;
                        end
                    endcase
                end
            end
            ST_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/connection_address_table.sv =====
// Top level of the connection address table: stream ports, result register,
// the handle and address stores and the lookup sequencer. Uses cat_pkg, cat_ram, cat_ctrl.
//
// Channel   Direction  Payload
// s_axis    in         tdata: command[1:0], conn_handle[17:2], peer_mac[65:18]
// m_axis    out        tdata: status[2:0], mac_out[50:3]
//
// A request scans the handle store at one entry per cycle until a match or the last
// entry, through the registered read port; an unknown command skips the scan.
// Reset clears the valid bits at once; there is no clearing pass.
// A result waits in the output register while the next request is already accepted
// and scanned; a stalled m_axis holds the sequencer only when the next result is ready.
`default_nettype none

module connection_address_table #(
    parameter int TABLE_ENTRIES = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // command, conn_handle, peer_mac from the lowest bit up
    input  wire logic [cat_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // status, mac_out from the lowest bit up
    output logic [cat_pkg::M_TDATA_W-1:0]        m_axis_tdata
);

    import cat_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic                 res_valid;
    logic                 res_ready;
    logic [STATUS_W-1:0]  res_status;
    logic [MAC_W-1:0]     res_mac;
    logic                 key_we;
    logic                 addr_we;
    logic [IDX_W-1:0]     waddr;
    logic [HANDLE_W-1:0]  key_wdata;
    logic [MAC_W-1:0]     addr_wdata;
    logic                 key_re;
    logic [IDX_W-1:0]     key_raddr;
    logic [HANDLE_W-1:0]  key_rdata;
    logic                 addr_re;
    logic [IDX_W-1:0]     addr_raddr;
    logic [MAC_W-1:0]     addr_rdata;

    logic                 r_m_valid, n_m_valid;
    logic [STATUS_W-1:0]  r_m_status, n_m_status;
    logic [MAC_W-1:0]     r_m_mac, n_m_mac;

    cat_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_cmd        (s_axis_tdata[CMD_W-1:0]),
        .i_handle     (s_axis_tdata[CMD_W +: HANDLE_W]),
        .i_mac        (s_axis_tdata[CMD_W+HANDLE_W +: MAC_W]),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_status     (res_status),
        .o_mac        (res_mac),
        .o_key_we     (key_we),
        .o_addr_we    (addr_we),
        .o_waddr      (waddr),
        .o_key_wdata  (key_wdata),
        .o_addr_wdata (addr_wdata),
        .o_key_re     (key_re),
        .o_key_raddr  (key_raddr),
        .i_key_rdata  (key_rdata),
        .o_addr_re    (addr_re),
        .o_addr_raddr (addr_raddr),
        .i_addr_rdata (addr_rdata)
    );

    cat_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (HANDLE_W),
        .AW    (IDX_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    cat_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (MAC_W),
        .AW    (IDX_W)
    ) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (addr_we),
        .i_waddr (waddr),
        .i_wdata (addr_wdata),
        .i_re    (addr_re),
        .i_raddr (addr_raddr),
        .o_rdata (addr_rdata)
    );

    always_comb begin
        res_ready  = !r_m_valid || m_axis_tready;
        n_m_valid  = r_m_valid;
        n_m_status = r_m_status;
        n_m_mac    = r_m_mac;
        if (res_ready) begin
            n_m_valid = res_valid;
            if (res_valid) begin
                n_m_status = res_status;
                n_m_mac    = res_mac;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_status <= n_m_status;
        r_m_mac    <= n_m_mac;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {(M_TDATA_W - STATUS_W - MAC_W)'(0), r_m_mac, r_m_status};

endmodule

`default_nettype wire
